@@ design/sem_pkg.sv @@
`timescale 1ns / 1ps

package sem_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CWIDTH_W  = 11;
    localparam int ROW_W     = 12;
    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 10;
    localparam int SUM_W     = 21;
    localparam int MAG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CWIDTH_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]    HEIGHT_RESET = 12'd480;
    localparam logic [CWIDTH_W-1:0] WIDTH_MIN    = 11'd3;
    localparam logic [CWIDTH_W-1:0] WIDTH_MAX    = CWIDTH_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0]    HEIGHT_MIN   = 12'd3;

    localparam logic [SUM_W-1:0] ROOT_BIT_START = SUM_W'(1) << (SUM_W - 1);

    typedef struct packed {
        logic [GRAD_W-1:0] ax;
        logic [GRAD_W-1:0] ay;
        logic              row_end;
        logic              frame_end;
    } sem_grad_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_ROOT,
        BK_HOLD
    } sem_back_state_t;

endpackage

@@ design/sobel_edge_magnitude.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// input     in         push / full        pixel
// result    out        pop / empty        magnitude, row_end, frame_end
// config    in         cfg_valid/ready    cfg_index, cfg_data
//
// The front takes one pixel per cycle while full is low; line store reads are registered.
// In the back each result is taken from the queue, squared, put through eleven root
// steps and loaded into the output register, waiting while that register is still full.
// The shared root unit sets the result rate.
// Reset clears counts, queues and the output; registers return to 640 x 480.
// full rises while a pixel that yields a result waits on a full gradient queue.

module sobel_edge_magnitude (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sem_pkg::PIX_W-1:0]         pixel,
    input  logic                              push,
    output logic                              full,
    output logic [sem_pkg::MAG_W-1:0]         magnitude,
    output logic                              row_end,
    output logic                              frame_end,
    output logic                              empty,
    input  logic                              pop,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sem_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import sem_pkg::*;

    logic [CWIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]    height_reg;
    logic [CWIDTH_W-1:0] width_eff;
    logic [ROW_W-1:0]    height_eff;

    sem_grad_t front_grad;
    sem_grad_t queue_grad;
    logic      grad_push;
    logic      grad_full;
    logic      grad_empty;
    logic      grad_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[CWIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[ROW_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < WIDTH_MIN)
            width_eff = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_reg;
        height_eff = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
    end

    sem_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .push       (push),
        .full       (full),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .grad       (front_grad),
        .grad_push  (grad_push),
        .grad_full  (grad_full)
    );

    sem_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_data (front_grad),
        .wr_en   (grad_push),
        .q_full  (grad_full),
        .rd_data (queue_grad),
        .rd_en   (grad_pop),
        .q_empty (grad_empty)
    );

    sem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grad      (queue_grad),
        .q_empty   (grad_empty),
        .q_pop     (grad_pop),
        .magnitude (magnitude),
        .row_end   (row_end),
        .frame_end (frame_end),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

@@ design/sem_front.sv @@
`timescale 1ns / 1ps

module sem_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [sem_pkg::PIX_W-1:0]         pixel,
    input  logic                              push,
    output logic                              full,
    input  logic [sem_pkg::CWIDTH_W-1:0]      width_eff,
    input  logic [sem_pkg::ROW_W-1:0]         height_eff,
    output sem_pkg::sem_grad_t                grad,
    output logic                              grad_push,
    input  logic                              grad_full
);
    import sem_pkg::*;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_rd_reg;
    logic [PIX_W-1:0] lo_rd_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             a_valid_reg;
    logic [PIX_W-1:0] a_px_reg;
    logic [COL_W-1:0] a_col_reg;
    logic             a_prod_reg;
    logic             a_rend_reg;
    logic             a_fend_reg;

    logic [PIX_W-1:0] win_reg  [3][3];
    logic [PIX_W-1:0] win_next [3][3];

    logic accept;
    logic advance;
    logic last_col;
    logic last_row;
    logic produce;

    logic [GRAD_W-1:0] top_sum;
    logic [GRAD_W-1:0] bot_sum;
    logic [GRAD_W-1:0] left_sum;
    logic [GRAD_W-1:0] right_sum;

    assign accept  = push && !full;
    assign advance = a_valid_reg && (!a_prod_reg || !grad_full);
    assign full    = a_valid_reg && !advance;

    assign last_col = ({1'b0, col_reg} + CWIDTH_W'(1)) >= width_eff;
    assign last_row = ({1'b0, row_reg} + (ROW_W + 1)'(1)) >= {1'b0, height_eff};
    assign produce  = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

    always_comb
    begin
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                a_valid_reg <= 1'b1;
            else if (advance)
                a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_px_reg   <= pixel;
            a_col_reg  <= col_reg;
            a_prod_reg <= produce;
            a_rend_reg <= last_col;
            a_fend_reg <= last_col && last_row;
            up_rd_reg  <= upper_mem[col_reg];
            lo_rd_reg  <= lower_mem[col_reg];
        end
        if (advance)
        begin
            upper_mem[a_col_reg] <= lo_rd_reg;
            lower_mem[a_col_reg] <= a_px_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_rd_reg;
        win_next[1][2] = lo_rd_reg;
        win_next[2][2] = a_px_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            win_reg <= win_next;
    end

    always_comb
    begin
        top_sum   = GRAD_W'(win_next[0][0]) + (GRAD_W'(win_next[0][1]) << 1)
                    + GRAD_W'(win_next[0][2]);
        bot_sum   = GRAD_W'(win_next[2][0]) + (GRAD_W'(win_next[2][1]) << 1)
                    + GRAD_W'(win_next[2][2]);
        left_sum  = GRAD_W'(win_next[0][0]) + (GRAD_W'(win_next[1][0]) << 1)
                    + GRAD_W'(win_next[2][0]);
        right_sum = GRAD_W'(win_next[0][2]) + (GRAD_W'(win_next[1][2]) << 1)
                    + GRAD_W'(win_next[2][2]);
        grad.ay = (top_sum >= bot_sum) ? top_sum - bot_sum : bot_sum - top_sum;
        grad.ax = (left_sum >= right_sum) ? left_sum - right_sum : right_sum - left_sum;
        grad.row_end   = a_rend_reg;
        grad.frame_end = a_fend_reg;
    end

    assign grad_push = advance && a_prod_reg;

endmodule

@@ design/sem_queue.sv @@
`timescale 1ns / 1ps

module sem_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  sem_pkg::sem_grad_t wr_data,
    input  logic               wr_en,
    output logic               q_full,
    output sem_pkg::sem_grad_t rd_data,
    input  logic               rd_en,
    output logic               q_empty
);
    import sem_pkg::*;

    sem_grad_t   slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_wr;
    logic        do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_empty = (count_reg == 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({do_wr, do_rd})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty || q_full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

@@ design/sem_back.sv @@
`timescale 1ns / 1ps

module sem_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sem_pkg::sem_grad_t          grad,
    input  logic                        q_empty,
    output logic                        q_pop,
    output logic [sem_pkg::MAG_W-1:0]   magnitude,
    output logic                        row_end,
    output logic                        frame_end,
    output logic                        empty,
    input  logic                        pop
);
    import sem_pkg::*;

    sem_back_state_t   state_reg;
    sem_back_state_t   state_next;

    sem_grad_t         item_reg;
    sem_grad_t         item_next;
    logic [SUM_W-1:0]  val_reg;
    logic [SUM_W-1:0]  val_next;
    logic [SUM_W-1:0]  res_reg;
    logic [SUM_W-1:0]  res_next;
    logic [SUM_W-1:0]  bit_reg;
    logic [SUM_W-1:0]  bit_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [MAG_W-1:0]  out_mag_reg;
    logic [MAG_W-1:0]  out_mag_next;
    logic              out_rend_reg;
    logic              out_rend_next;
    logic              out_fend_reg;
    logic              out_fend_next;

    logic [SUM_W:0]    trial;
    logic              out_take;

    assign out_take  = pop && out_valid_reg;
    assign empty     = !out_valid_reg;
    assign magnitude = out_mag_reg;
    assign row_end   = out_rend_reg;
    assign frame_end = out_fend_reg;
    assign trial     = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        val_next       = val_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_mag_next   = out_mag_reg;
        out_rend_next  = out_rend_reg;
        out_fend_next  = out_fend_reg;
        q_pop          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    item_next  = grad;
                    state_next = BK_SQUARE;
                end
            end
            BK_SQUARE:
            begin
                val_next   = SUM_W'(item_reg.ax) * SUM_W'(item_reg.ax)
                             + SUM_W'(item_reg.ay) * SUM_W'(item_reg.ay);
                res_next   = '0;
                bit_next   = ROOT_BIT_START;
                state_next = BK_ROOT;
            end
            BK_ROOT:
            begin
                if ({1'b0, val_reg} >= trial)
                begin
                    val_next = val_reg - trial[SUM_W-1:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                    state_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_mag_next   = res_reg[MAG_W-1:0];
                    out_rend_next  = item_reg.row_end;
                    out_fend_next  = item_reg.frame_end;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        val_reg      <= val_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        out_mag_reg  <= out_mag_next;
        out_rend_reg <= out_rend_next;
        out_fend_reg <= out_fend_next;
    end

`ifndef NO_ASSERTIONS
    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ROOT) |-> $onehot(bit_reg))
        else $error("root step bit is not a single power of four");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_HOLD) |-> (res_reg <= SUM_W'(1442)))
        else $error("root result out of range");

    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && state_reg != BK_HOLD) |=> !out_valid_reg)
        else $error("result stayed after transfer");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

import sem_pkg::*;

typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             row_end;
    logic             frame_end;
} edge_result_t;

class sobel_tracker;
    logic [CWIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]    height_reg;
    logic [PIX_W-1:0]    upper_row [MAX_WIDTH];
    logic [PIX_W-1:0]    lower_row [MAX_WIDTH];
    logic [PIX_W-1:0]    win [3][3];
    int                  column;
    int                  row;
    edge_result_t        expected_edges [$];
    int                  failures;
    int                  pixels;
    int                  results;
    int                  row_ends;
    int                  frame_ends;

    function new();
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        foreach (upper_row[i]) begin
            upper_row[i] = '0;
            lower_row[i] = '0;
        end
        foreach (win[r, c]) win[r][c] = '0;
        column     = 0;
        row        = 0;
        failures   = 0;
        pixels     = 0;
        results    = 0;
        row_ends   = 0;
        frame_ends = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = data[CWIDTH_W-1:0];
        else if (idx == CFG_IMAGE_HEIGHT)
            height_reg = data[ROW_W-1:0];
    endfunction

    function int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 3)
            w = 3;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w;
    endfunction

    function int eff_height();
        int h;
        h = int'(height_reg);
        if (h < 3)
            h = 3;
        return h;
    endfunction

    function int floor_root(int v);
        int r;
        int t;
        r = 0;
        for (int b = 10; b >= 0; b--) begin
            t = r + (1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function int pending();
        return expected_edges.size();
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
        int           w;
        int           h;
        int           gx;
        int           gy;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] lo;
        bit           last_col;
        bit           last_row;
        edge_result_t res;
        w = eff_width();
        h = eff_height();
        up = upper_row[column];
        lo = lower_row[column];
        upper_row[column] = lo;
        lower_row[column] = px;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = px;
        last_col = (column + 1 >= w);
        last_row = (row + 1 >= h);
        if (row >= 2 && column >= 2) begin
            gy = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
               - int'(win[2][0]) - 2 * int'(win[2][1]) - int'(win[2][2]);
            gx = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0])
               - int'(win[0][2]) - 2 * int'(win[1][2]) - int'(win[2][2]);
            res.magnitude = MAG_W'(floor_root(gx * gx + gy * gy));
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
            expected_edges.push_back(res);
        end
        if (last_col) begin
            column = 0;
            row    = last_row ? 0 : row + 1;
        end
        else begin
            column = column + 1;
        end
        pixels++;
    endfunction

    function void check_result(logic [MAG_W-1:0] mag, logic re, logic fe);
        edge_result_t want;
        if (expected_edges.size() == 0) begin
            $error("unexpected edge result: magnitude %0d row_end %0b frame_end %0b",
                   mag, re, fe);
            failures++;
            return;
        end
        want = expected_edges.pop_front();
        results++;
        if (want.row_end)
            row_ends++;
        if (want.frame_end)
            frame_ends++;
        if (mag !== want.magnitude) begin
            $error("magnitude: expected %0d, got %0d", want.magnitude, mag);
            failures++;
        end
        if (re !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, re);
            failures++;
        end
        if (fe !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, fe);
            failures++;
        end
    endfunction
endclass

module tb_top;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 1000;
    localparam int RANDOM_PIXELS = 350;

    typedef enum int {
        FILL_NOISE,
        FILL_BINARY,
        FILL_RAMP,
        FILL_SPARSE
    } fill_t;

    logic                 clk;
    logic                 rst_n;
    logic [PIX_W-1:0]     pixel;
    logic                 push;
    logic                 full;
    logic [MAG_W-1:0]     magnitude;
    logic                 row_end;
    logic                 frame_end;
    logic                 empty;
    logic                 pop = 1'b0;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    sobel_tracker sb = new();

    int burst_left = 0;
    int open_left  = 0;
    int shut_left  = 0;
    int idle_cycles = 0;
    int settings_count = 0;
    int ramp_base;
    int ramp_dx;
    int ramp_dy;

    sobel_edge_magnitude u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .push      (push),
        .full      (full),
        .magnitude (magnitude),
        .row_end   (row_end),
        .frame_end (frame_end),
        .empty     (empty),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: long open stretches or short bursts between stalls
    always @(negedge clk)
    begin
        if (open_left == 0 && shut_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                open_left = $urandom_range(50, 300);
                shut_left = 0;
            end
            else begin
                open_left = $urandom_range(1, 8);
                shut_left = $urandom_range(1, 30);
            end
        end
        if (open_left > 0) begin
            pop <= 1'b1;
            open_left--;
        end
        else begin
            pop <= 1'b0;
            shut_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(magnitude, row_end, frame_end);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [PIX_W-1:0] pick_pixel(fill_t mode);
        case (mode)
            FILL_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            FILL_RAMP:   return PIX_W'(ramp_base + sb.column * ramp_dx + sb.row * ramp_dy);
            FILL_SPARSE: return ($urandom_range(0, 7) == 0) ? PIX_W'($urandom_range(0, 255))
                                                              : PIX_W'(ramp_base);
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 64);
        end
        pixel <= p;
        push  <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_pixel(p);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic feed(input int count, input fill_t mode);
        repeat (count) send_pixel(pick_pixel(mode));
    endtask

    task automatic feed_to_boundary(input fill_t mode);
        while (sb.column != 0 || sb.row != 0)
            send_pixel(pick_pixel(mode));
    endtask

    // hold input low until every result is out and the front has gone quiet
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_frame(input bit do_w, input logic [CFG_DAT_W-1:0] wdata,
                             input bit do_h, input logic [CFG_DAT_W-1:0] hdata);
        bit any;
        bit enable;
        any = 1'b0;
        for (int i = 0; i < 2; i++) begin
            enable = (i == 0) ? do_w : do_h;
            if (enable) begin
                cfg_valid <= 1'b1;
                cfg_index <= (i == 0) ? CFG_IMAGE_WIDTH : CFG_IMAGE_HEIGHT;
                cfg_data  <= (i == 0) ? wdata : hdata;
                @(posedge clk);
                while (!cfg_ready) @(posedge clk);
                sb.write_reg((i == 0) ? CFG_IMAGE_WIDTH : CFG_IMAGE_HEIGHT,
                             (i == 0) ? wdata : hdata);
                @(negedge clk);
                any = 1'b1;
            end
        end
        if (any)
            cfg_valid <= 1'b0;
        settings_count++;
    endtask

    initial
    begin
        int                   ew;
        int                   eh;
        int                   phase_no;
        bit                   tall;
        bit                   do_w;
        bit                   do_h;
        logic [CFG_DAT_W-1:0] wdata;
        logic [CFG_DAT_W-1:0] hdata;
        fill_t                fill;

        rst_n     = 1'b0;
        push      = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        ramp_base = 0;
        ramp_dx   = 0;
        ramp_dy   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // diagonal step edge over a flat background, full-scale pixels
        set_frame(1'b1, 12'd5, 1'b1, 12'd5);
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                send_pixel((c + r < 4) ? 8'hFF : 8'h00);
        drain();

        phase_no = 0;
        while (sb.pixels < RANDOM_PIXELS) begin
            phase_no++;
            tall  = (phase_no == 1) || ($urandom_range(0, 9) == 0);
            wdata = {1'($urandom_range(0, 1)),
                     11'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 12))};
            if (tall)
                hdata = 12'hFFF;
            else if ($urandom_range(0, 3) == 0)
                hdata = 12'($urandom_range(0, 2));
            else
                hdata = 12'($urandom_range(3, 8));
            if (phase_no == 2) begin
                wdata = 12'h800;
                hdata = 12'h000;
            end
            do_w = ($urandom_range(0, 7) != 0) || (phase_no <= 2);
            do_h = ($urandom_range(0, 7) != 0) || tall || (phase_no <= 2);
            set_frame(do_w, wdata, do_h, hdata);
            fill      = fill_t'($urandom_range(0, 3));
            ramp_base = $urandom_range(0, 255);
            ramp_dx   = $urandom_range(0, 60);
            ramp_dy   = $urandom_range(0, 60);
            ew = sb.eff_width();
            eh = sb.eff_height();
            if (eh > 8) begin
                feed(ew * $urandom_range(3, 10) + $urandom_range(0, ew - 1), fill);
                drain();
                set_frame(1'b0, '0, 1'b1, 12'($urandom_range(0, 8)));
                feed_to_boundary(fill);
            end
            else if ($urandom_range(0, 3) == 0) begin
                feed($urandom_range(1, ew * eh - 1), fill);
                drain();
                if ($urandom_range(0, 1) == 0)
                    set_frame(1'b0, '0, 1'b1, 12'($urandom_range(0, 8)));
                else
                    set_frame(1'b1, 12'($urandom_range(0, ew)), 1'b0, '0);
                feed_to_boundary(fill);
            end
            else begin
                feed(ew * eh * $urandom_range(1, 2), fill);
            end
            drain();
        end

        // widest row the line stores allow, then narrow the frame partway into row two
        set_frame(1'b1, 12'hFFF, 1'b1, 12'h000);
        feed(MAX_WIDTH + 5, FILL_NOISE);
        drain();
        set_frame(1'b1, 12'd8, 1'b0, '0);
        feed_to_boundary(FILL_NOISE);
        drain();

        if (sb.pending() != 0) begin
            $error("%0d edge results never arrived", sb.pending());
            sb.failures++;
        end
        $display("Sobel run: %0d pixels over %0d register settings, widths 3 to %0d",
                 sb.pixels, settings_count, MAX_WIDTH);
        $display("Checked %0d magnitudes, %0d row ends, %0d frame ends",
                 sb.results, sb.row_ends, sb.frame_ends);
        if (sb.failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
design/sem_pkg.sv
design/sem_front.sv
design/sem_queue.sv
design/sem_back.sv
design/sobel_edge_magnitude.sv
tb/tb_top.sv
